// ===== hdl/hecr_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex echo-cancelling relay: shared package
// Item types, code enumerations and default constants for the relay.
// ----------------------------------------------------------------------------
package hecr_pkg;

   localparam int TX_FIFO_DEPTH_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT    = 8;
   localparam int CSR_DATA_W            = 32;
   localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd30000;

   typedef enum logic {
      CSR_ENABLE       = 1'b0,
      CSR_IDLE_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_ECHO     = 3'd0,
      ACT_FORWARD  = 3'd1,
      ACT_REFUSED  = 3'd2,
      ACT_INACTIVE = 3'd3,
      ACT_RESYNC   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      LOCK_IDLE = 2'd0,
      LOCK_REQ  = 2'd1,
      LOCK_RSP  = 2'd2
   } lock_type;

   typedef enum logic {
      FUNC_BYTE     = 1'b0,
      FUNC_OVERFLOW = 1'b1
   } func_type;

   typedef struct packed {
      func_type    func;
      logic        source_side;
      logic [7:0]  rx_byte;
      logic [31:0] now_ticks;
      logic [4:0]  dest_tx_fill;
   } req_type;

   typedef struct packed {
      action_type action;
      logic       tx_side;
      logic [7:0] tx_byte;
      lock_type   lock_state;
      logic       timeout_fired;
      logic       lock_taken;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

// ===== hdl/hecr_in_reg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex echo-cancelling relay: input register
// Holds one accepted item until the decision stage moves it on.
// ----------------------------------------------------------------------------
module hecr_in_reg
   import hecr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   input  logic          advance,
   output logic          item_valid,
   output req_type       item_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// ===== hdl/hecr_relay_core.sv =====
// ----------------------------------------------------------------------------
// Half-duplex echo-cancelling relay: decision logic and relay state
// Classifies the item in the input register and updates lock and counts.
// ----------------------------------------------------------------------------
module hecr_relay_core
   import hecr_pkg::*;
#(
   parameter int TX_FIFO_DEPTH = TX_FIFO_DEPTH_DEFAULT,
   parameter int COUNT_BITS    = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  stage_ctl_type         ctl,
   input  req_type               item,
   output rsp_type               result
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [8:0] DEPTH = 9'(TX_FIFO_DEPTH);

   logic                  enable_ff;
   logic                  enable_in;
   logic [31:0]           timeout_ff;
   logic [31:0]           timeout_in;
   lock_type              lock_ff;
   lock_type              lock_in;
   logic [COUNT_BITS-1:0] fwd_ff;
   logic [COUNT_BITS-1:0] fwd_in;
   logic [COUNT_BITS-1:0] echo_ff;
   logic [COUNT_BITS-1:0] echo_in;
   logic [31:0]           last_ff;
   logic [31:0]           last_in;
   logic                  clear_cfg;
   lock_type              own;
   lock_type              other;
   logic [31:0]           elapsed;

   always_comb begin
      enable_in  = enable_ff;
      timeout_in = timeout_ff;
      clear_cfg  = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_wr_data[0];
               clear_cfg = csr_wr_data[0];
            end
            CSR_IDLE_TIMEOUT: begin
               timeout_in = csr_wr_data[31:0];
            end
            default: begin
               enable_in = enable_ff;
            end
         endcase
      end
   end

   always_comb begin
      lock_in              = lock_ff;
      fwd_in               = fwd_ff;
      echo_in              = echo_ff;
      last_in              = last_ff;
      result               = '0;
      result.action        = ACT_INACTIVE;
      own                  = item.source_side ? LOCK_RSP : LOCK_REQ;
      other                = item.source_side ? LOCK_REQ : LOCK_RSP;
      elapsed              = item.now_ticks - last_ff;
      if (item.func == FUNC_OVERFLOW) begin
         lock_in       = LOCK_IDLE;
         fwd_in        = '0;
         echo_in       = '0;
         result.action = ACT_RESYNC;
      end else if (enable_ff) begin
         if ((lock_ff != LOCK_IDLE) && (elapsed > timeout_ff)) begin
            lock_in              = LOCK_IDLE;
            fwd_in               = '0;
            echo_in              = '0;
            result.timeout_fired = 1'b1;
         end
         last_in        = item.now_ticks;
         result.tx_side = ~item.source_side;
         if ((lock_in == other) && (echo_in < fwd_in)) begin
            if (echo_in != COUNT_MAX) begin
               echo_in = echo_in + 1'b1;
            end
            result.action = ACT_ECHO;
         end else begin
            if (lock_in != own) begin
               lock_in           = own;
               fwd_in            = '0;
               echo_in           = '0;
               result.lock_taken = 1'b1;
            end
            if (9'(item.dest_tx_fill) < DEPTH) begin
               if (fwd_in != COUNT_MAX) begin
                  fwd_in = fwd_in + 1'b1;
               end
               result.action  = ACT_FORWARD;
               result.tx_byte = item.rx_byte;
            end else begin
               result.action = ACT_REFUSED;
            end
         end
      end
      result.lock_state = lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         timeout_ff <= IDLE_TIMEOUT_RESET;
         lock_ff    <= LOCK_IDLE;
         fwd_ff     <= '0;
         echo_ff    <= '0;
         last_ff    <= '0;
      end else begin
         enable_ff  <= enable_in;
         timeout_ff <= timeout_in;
         if (clear_cfg) begin
            lock_ff <= LOCK_IDLE;
            fwd_ff  <= '0;
            echo_ff <= '0;
         end else if (ctl.advance) begin
            lock_ff <= lock_in;
            fwd_ff  <= fwd_in;
            echo_ff <= echo_in;
            last_ff <= last_in;
         end
      end
   end

   a_echo_within_fwd: assert property (@(posedge clock) disable iff (reset)
      echo_ff <= fwd_ff)
      else $error("echo count exceeds forwarded count");

   a_idle_counts_zero: assert property (@(posedge clock) disable iff (reset)
      (lock_ff == LOCK_IDLE) |-> ((fwd_ff == '0) && (echo_ff == '0)))
      else $error("counts held while lock is idle");

   a_resync_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && ctl.valid && (item.func == FUNC_OVERFLOW))
      |=> (lock_ff == LOCK_IDLE))
      else $error("resync item did not release the lock");

   a_advance_needs_item: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |-> ctl.valid)
      else $error("decision stage advanced without an item");

endmodule

// ===== hdl/hecr_out_reg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex echo-cancelling relay: result register
// Holds one result item until the receiving side takes it.
// ----------------------------------------------------------------------------
module hecr_out_reg
   import hecr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  rsp_type       result,
   output stage_ctl_type ctl,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    advance;

   assign advance  = item_valid & (~valid_ff | ~rsp_stall);
   assign valid_in = advance | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign ctl.valid   = item_valid;
   assign ctl.advance = advance;
   assign rsp_valid   = valid_ff;
   assign rsp_data    = data_ff;

endmodule

// ===== hdl/half_duplex_echo_cancel_relay.sv =====
// ----------------------------------------------------------------------------
// Half-duplex echo-cancelling relay: top level
// Relays bytes between the two halves of a split half-duplex bus, dropping
// echoes by count and holding one direction lock at a time.
//
//   Channel   Direction  Ports                               Item
//   req       in         req_valid, req_stall, req_data      received byte or overflow
//   rsp       out        rsp_valid, rsp_stall, rsp_data      relay decision
//   csr       in         csr_wr_en, csr_index, csr_wr_data   register write
//
// An accepted item is held in the input register, decided combinationally and
// written to the result register, from which the receiving side takes it.
// One item is accepted every cycle while results are taken; the decision for
// each item is combinational.
// A stalled result holds the decision stage, which then stalls the input.
// Reset is synchronous; the relay comes up disabled with the lock idle.
// ----------------------------------------------------------------------------
module half_duplex_echo_cancel_relay
   import hecr_pkg::*;
#(
   parameter int TX_FIFO_DEPTH = TX_FIFO_DEPTH_DEFAULT,
   parameter int COUNT_BITS    = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic          item_valid;
   req_type       item_data;
   rsp_type       result;
   stage_ctl_type ctl;

   hecr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (ctl.advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   hecr_relay_core #(
      .TX_FIFO_DEPTH (TX_FIFO_DEPTH),
      .COUNT_BITS    (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .item        (item_data),
      .result      (result)
   );

   hecr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .ctl        (ctl),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && rsp_valid && rsp_stall))
      else $error("input stalled while the pipeline could move");

   a_item_reaches_result: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !rsp_valid) |=> rsp_valid)
      else $error("held item did not reach the result register");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> !req_stall)
      else $error("input stalled with an empty input register");

endmodule
